/* rtl/cumulative_ack_retransmit_buffer_core_assert.svh */
// assertion macros for the retransmit buffer core
`ifndef CUMULATIVE_ACK_RETRANSMIT_BUFFER_CORE_ASSERT_SVH
`define CUMULATIVE_ACK_RETRANSMIT_BUFFER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CABR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cabr check failed");

// next-cycle implication, checked out of reset
`define CABR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cabr check failed");

`endif

/* rtl/cabr_pkg.sv */
`default_nettype none
package cabr_pkg;

    localparam int DEPTH        = 64;
    localparam int PAYLOAD_BITS = 64;

    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 31;
    localparam int RID_W    = 32;
    localparam int PAY_W    = 64;
    localparam int OCC_W    = 7;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 104;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD,
        CMD_ACK,
        CMD_FIND
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK,
        STAT_NOT_FOUND,
        STAT_FULL
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    // sum is below twice the depth, so one conditional subtract wraps it
    function automatic logic [SLOT_W-1:0] slot_wrap(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] w;
        w = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
        return w[SLOT_W-1:0];
    endfunction

    function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] c);
        logic [OCC_W+CNT_W-1:0] w;
        w = {{OCC_W{1'b0}}, c};
        return w[OCC_W-1:0];
    endfunction

    function automatic logic [PAY_W-1:0] pay_widen(input logic [PAYLOAD_BITS-1:0] p);
        logic [PAY_W+PAYLOAD_BITS-1:0] w;
        w = {{PAY_W{1'b0}}, p};
        return w[PAY_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/cumulative_ack_retransmit_buffer_core.sv */
// Sender-side retransmission buffer: a ring of DEPTH payloads under contiguous
// 31-bit ids, released by cumulative acknowledgement.
// Input channel s_*: one command per transaction (add, ack or find), with the
// id, the last-sent id and the payload in s_tdata and the command in s_tuser.
// Result channel m_*: exactly one result per command, in order, with the
// status in m_tuser and id, payload and occupancy in m_tdata.
// Steps: the input transaction is captured, then executed, then loaded into
// the output register, which raises m_tvalid.
// A new command is taken only after the last one has reached its output load
// step; the execute step drives the write and read ports of the payload RAM.
// The input is taken again while a result still waits on m_tready; a stalled
// result holds m_tvalid and m_tdata, and the block then stops in its output
// step until the result is taken, holding s_tready low.
// Reset empties the ring (oldest id register zero, occupancy zero); no clearing
// pass is needed since only written slots are ever read.
`default_nettype none
module cumulative_ack_retransmit_buffer_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // seq_id[30:0], last_sent_id[62:31], payload_in[126:63], zero pad
    input  wire logic [cabr_pkg::S_DATA_W-1:0]     s_tdata,
    // cmd
    input  wire logic [cabr_pkg::CMD_W-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // result_id[31:0], payload_out[95:32], occupancy[102:96], zero pad
    output logic      [cabr_pkg::M_DATA_W-1:0]     m_tdata,
    // status
    output logic      [cabr_pkg::STAT_W-1:0]       m_tuser
);
    import cabr_pkg::*;

`include "cumulative_ack_retransmit_buffer_core_assert.svh"

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    cabr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    cabr_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (dp_cmd),
        .stat     (dp_stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    `CABR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready && !dp_cmd.load_out)
    `CABR_ASSERT_NOW(a_fail_id, m_tvalid && (m_tuser != STAT_OK), m_tdata[RID_W-1:0] == '1)
    `CABR_ASSERT_NOW(a_pay_only_ok, m_tvalid && (m_tdata[RID_W+PAY_W-1:RID_W] != '0), m_tuser == STAT_OK)
    `CABR_ASSERT_NEXT(a_load_sets_valid, dp_cmd.load_out, m_tvalid)

endmodule
`default_nettype wire

/* rtl/cabr_ram.sv */
`default_nettype none
module cabr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/cabr_ctrl.sv */
`default_nettype none
module cabr_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire cabr_pkg::dp_stat_t stat,
    output cabr_pkg::dp_cmd_t       cmd
);
    import cabr_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: state_next = S_DONE;
            S_DONE: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            S_EXEC: cmd.exec = 1'b1;
            S_DONE: cmd.load_out = stat.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/cabr_dp.sv */
`default_nettype none
module cabr_dp (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cabr_pkg::dp_cmd_t                 cmd,
    output cabr_pkg::dp_stat_t                     stat,
    input  wire logic [cabr_pkg::S_DATA_W-1:0]     s_tdata,
    input  wire logic [cabr_pkg::CMD_W-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [cabr_pkg::M_DATA_W-1:0]     m_tdata,
    output logic      [cabr_pkg::STAT_W-1:0]       m_tuser
);
    import cabr_pkg::*;

    // latched transaction
    logic [CMD_W-1:0]        cmd_reg;
    logic [ID_W-1:0]         seq_reg;
    logic [RID_W-1:0]        last_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;

    // ring state
    logic [ID_W-1:0]   oldest_seq_reg, oldest_seq_next;
    logic [SLOT_W-1:0] oldest_slot_reg, oldest_slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // staged result
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [RID_W-1:0]  res_id_reg, res_id_next;
    logic              res_hit_reg, res_hit_next;

    // output register
    logic              m_tvalid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [RID_W-1:0]  out_id_reg;
    logic [PAY_W-1:0]  out_pay_reg;
    logic [OCC_W-1:0]  out_occ_reg;

    logic [ID_W-1:0]         diff;
    logic [CNT_W-1:0]        off;
    logic                    held;
    logic                    full;
    logic [ID_W-1:0]         add_id;
    logic [SLOT_W-1:0]       add_slot;
    logic [SLOT_W-1:0]       find_slot;
    logic [SLOT_W-1:0]       ack_slot;
    logic                    ram_we;
    logic                    ram_re;
    logic [PAYLOAD_BITS-1:0] ram_rdata;

    assign diff      = seq_reg - oldest_seq_reg;
    assign off       = diff[CNT_W-1:0];
    assign held      = diff < ID_W'(count_reg);
    assign full      = count_reg == CNT_W'(DEPTH);
    assign add_id    = (count_reg == '0) ? (last_reg[ID_W-1:0] + ID_W'(1))
                                         : (oldest_seq_reg + ID_W'(count_reg));
    assign add_slot  = slot_wrap(SUM_W'(oldest_slot_reg) + SUM_W'(count_reg));
    assign find_slot = slot_wrap(SUM_W'(oldest_slot_reg) + SUM_W'(off));
    assign ack_slot  = slot_wrap(SUM_W'(oldest_slot_reg) + SUM_W'(off) + SUM_W'(1));

    assign ram_we = cmd.exec && (cmd_reg == CMD_ADD) && !full;
    assign ram_re = cmd.exec && (cmd_reg == CMD_FIND) && held;

    cabr_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (add_slot),
        .wdata (pay_reg),
        .re    (ram_re),
        .raddr (find_slot),
        .rdata (ram_rdata)
    );

    always_comb begin
        oldest_seq_next  = oldest_seq_reg;
        oldest_slot_next = oldest_slot_reg;
        count_next       = count_reg;
        res_status_next  = STAT_NOT_FOUND;
        res_id_next      = '1;
        res_hit_next     = 1'b0;
        case (cmd_reg)
            CMD_ADD: begin
                if (full) begin
                    res_status_next = STAT_FULL;
                end else begin
                    if (count_reg == '0) begin
                        oldest_seq_next = add_id;
                    end
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = STAT_OK;
                    res_id_next     = {1'b0, add_id};
                end
            end
            CMD_ACK: begin
                if (held) begin
                    oldest_slot_next = ack_slot;
                    oldest_seq_next  = seq_reg + ID_W'(1);
                    count_next       = count_reg - off - CNT_W'(1);
                    res_status_next  = STAT_OK;
                    res_id_next      = {1'b0, seq_reg};
                end
            end
            CMD_FIND: begin
                if (held) begin
                    res_status_next = STAT_OK;
                    res_id_next     = {1'b0, seq_reg};
                    res_hit_next    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_reg  <= s_tuser;
            seq_reg  <= s_tdata[ID_W-1:0];
            last_reg <= s_tdata[ID_W+RID_W-1:ID_W];
            pay_reg  <= s_tdata[ID_W+RID_W+PAYLOAD_BITS-1:ID_W+RID_W];
        end
        if (cmd.exec) begin
            res_status_reg <= res_status_next;
            res_id_reg     <= res_id_next;
            res_hit_reg    <= res_hit_next;
        end
        if (cmd.load_out) begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_pay_reg    <= res_hit_reg ? pay_widen(ram_rdata) : '0;
            out_occ_reg    <= occ_of(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_seq_reg  <= '0;
            oldest_slot_reg <= '0;
            count_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cmd.exec) begin
                oldest_seq_reg  <= oldest_seq_next;
                oldest_slot_reg <= oldest_slot_next;
                count_reg       <= count_next;
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tuser       = out_status_reg;
    assign m_tdata       = {1'b0, out_occ_reg, out_pay_reg, out_id_reg};

endmodule
`default_nettype wire
